// ===== hdl/ftacc_pkg.sv =====
// Shared types and constants for the fixed-step tick accumulator.
// Holds request/result payload structs, register indexes and control structs.
// No dependencies.
package ftacc_pkg;

	// Nanoseconds in one second; one tick is worth denominator times this.
	localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;

	// Divider widths: dividend/quotient and divisor.
	localparam int DIV_W   = 66;
	localparam int DVS_W   = 50;
	localparam int DCNT_W  = $clog2(DIV_W + 1);

	// Request codes.
	localparam logic [1:0] REQ_FRAME   = 2'd0;
	localparam logic [1:0] REQ_ADVANCE = 2'd1;
	localparam logic [1:0] REQ_RESUME  = 2'd2;
	localparam logic [1:0] REQ_UNUSED  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_RATE_NUM   = 3'd0;
	localparam logic [2:0] REG_RATE_DEN   = 3'd1;
	localparam logic [2:0] REG_MAX_TICKS  = 3'd2;
	localparam logic [2:0] REG_FIXED_TICKS = 3'd3;
	localparam logic [2:0] REG_FIXED_MODE = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] frame_ns;
		logic [63:0]        tick_value;
	} ftacc_in_t;

	typedef struct packed {
		logic [7:0]  ticks_to_run;
		logic [63:0] discarded_total_ns;
		logic [15:0] alpha_fraction;
		logic [31:0] capped_frame_count;
		logic [63:0] current_tick;
	} ftacc_out_t;

	// Which division the shared divider runs.
	typedef enum logic [1:0] {
		DSEL_ACC,
		DSEL_LOST,
		DSEL_ALPHA
	} div_sel_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_ACC,
		ST_DIV_A,
		ST_WAIT_A,
		ST_KEEP,
		ST_DIFF,
		ST_DIV_L,
		ST_WAIT_L,
		ST_APPLY,
		ST_DIV_F,
		ST_WAIT_F,
		ST_FIN
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic     load;
		logic     prep;
		logic     acc_upd;
		logic     div_start;
		div_sel_t div_sel;
		logic     keep_calc;
		logic     diff_calc;
		logic     cap_apply;
		logic     fin;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic div_done;
		logic need_cap;
		logic out_free;
	} status_t;

endpackage

// ===== hdl/ftacc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on ftacc_pkg for widths.
module ftacc_div
	import ftacc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	logic [DIV_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic              fits;
	logic [DVS_W:0]    diff;

	// Shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Control: iteration counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Data: quotient bits shift into the dividend register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[DVS_W-1:0];
			end else begin
				rem_q <= trial[DVS_W-1:0];
			end
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/ftacc_dp.sv =====
// Datapath: configuration, accumulator state, divider and output register.
// Depends on ftacc_pkg and ftacc_div.
module ftacc_dp
	import ftacc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [19:0] cfg_data,
	input  ftacc_in_t  in_data,
	input  cmd_t       cmd,
	output status_t    status,
	output logic       out_valid,
	input  logic       out_ready,
	output ftacc_out_t out_data
);

	logic [19:0] num_cfg_q;
	logic [19:0] den_cfg_q;
	logic [7:0]  cap_q;
	logic [7:0]  fixed_ticks_q;
	logic        fixed_q;

	logic [1:0]  req_q;
	logic [31:0] e_q;
	logic [63:0] tv_q;
	logic [19:0] num_q;
	logic [49:0] step_q;
	logic [50:0] prod_q;
	logic [63:0] acc_q;
	logic [63:0] tick_q;
	logic [63:0] disc_q;
	logic [31:0] capped_q;
	logic [31:0] avail_q;
	logic [49:0] rem_q;
	logic [63:0] keep_q;
	logic [63:0] diff_q;
	logic [15:0] alpha_q;
	div_sel_t    sel_q;
	logic        out_valid_q;
	ftacc_out_t  out_q;

	logic [19:0]      num_eff;
	logic [19:0]      den_eff;
	logic             e_pos;
	logic [DIV_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic [DVS_W-1:0] div_rem;
	logic             over_cap;
	logic [64:0]      disc_sum;
	logic [7:0]       ticks;
	logic [57:0]      keep_prod;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cfg_q     <= 20'd60;
			den_cfg_q     <= 20'd1;
			cap_q         <= 8'd8;
			fixed_ticks_q <= 8'd1;
			fixed_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATE_NUM:    num_cfg_q     <= cfg_data;
				REG_RATE_DEN:    den_cfg_q     <= cfg_data;
				REG_MAX_TICKS:   cap_q         <= cfg_data[7:0];
				REG_FIXED_TICKS: fixed_ticks_q <= cfg_data[7:0];
				REG_FIXED_MODE:  fixed_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A zero rate term counts as one.
	always_comb begin
		num_eff = (num_cfg_q == '0) ? 20'd1 : num_cfg_q;
		den_eff = (den_cfg_q == '0) ? 20'd1 : den_cfg_q;
		e_pos   = !e_q[31] && (e_q != '0);
	end

	// Divider operand selection; the divider samples operands only on start.
	always_comb begin
		case (cmd.div_sel)
			DSEL_ACC: begin
				div_dvd = {2'b00, acc_q};
				div_dvs = step_q;
			end
			DSEL_LOST: begin
				div_dvd = {2'b00, diff_q};
				div_dvs = {30'd0, num_q};
			end
			DSEL_ALPHA: begin
				div_dvd = {rem_q, 16'd0};
				div_dvs = step_q;
			end
			default: begin
				div_dvd = {2'b00, acc_q};
				div_dvs = step_q;
			end
		endcase
	end

	ftacc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Cap test, discard sum (saturated when applied), keep product and tick count.
	always_comb begin
		over_cap  = (avail_q[31:8] != '0) || (avail_q[7:0] > cap_q);
		disc_sum  = {1'b0, disc_q} + {1'b0, div_quo[63:0]};
		keep_prod = cap_q * step_q;
		if (req_q != REQ_FRAME) begin
			ticks = 8'd0;
		end else if (fixed_q) begin
			ticks = fixed_ticks_q;
		end else if (over_cap) begin
			ticks = cap_q;
		end else begin
			ticks = avail_q[7:0];
		end
	end

	// Request operands, per-request products and divider results.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data.req_type;
			e_q   <= in_data.frame_ns;
			tv_q  <= in_data.tick_value;
		end
		if (cmd.prep) begin
			num_q  <= num_eff;
			step_q <= den_eff * NS_PER_SECOND;
			prod_q <= e_pos ? e_q[30:0] * num_eff : 51'd0;
		end
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
		end
		if (div_done && sel_q == DSEL_ACC) begin
			avail_q <= div_quo[31:0];
			rem_q   <= div_rem;
		end
		if (div_done && sel_q == DSEL_ALPHA) begin
			alpha_q <= div_quo[15:0];
		end
		if (cmd.keep_calc) begin
			keep_q <= 64'(keep_prod) + 64'(rem_q);
		end
		if (cmd.diff_calc) begin
			diff_q <= acc_q - keep_q;
		end
	end

	// Architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			tick_q   <= '0;
			disc_q   <= '0;
			capped_q <= '0;
		end else begin
			if (cmd.acc_upd) begin
				case (req_q)
					REQ_FRAME: begin
						if (!fixed_q) begin
							acc_q <= acc_q + 64'(prod_q);
						end
					end
					REQ_ADVANCE: begin
						tick_q <= tick_q + 64'd1;
						if (!fixed_q) begin
							acc_q <= (acc_q >= 64'(step_q)) ? acc_q - 64'(step_q) : 64'd0;
						end
					end
					REQ_RESUME: begin
						tick_q <= tv_q;
						acc_q  <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.cap_apply) begin
				acc_q  <= keep_q;
				disc_q <= disc_sum[64] ? '1 : disc_sum[63:0];
				if (capped_q != '1) begin
					capped_q <= capped_q + 32'd1;
				end
			end
		end
	end

	// Output register; the lost-ns quotient is consumed in the same cycle as cap_apply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q.ticks_to_run       <= ticks;
			out_q.discarded_total_ns <= fixed_q ? 64'd0 : disc_q;
			out_q.alpha_fraction     <= fixed_q ? 16'd0 : alpha_q;
			out_q.capped_frame_count <= capped_q;
			out_q.current_tick       <= tick_q;
		end
	end

	assign status.div_done = div_done;
	assign status.need_cap = (req_q == REQ_FRAME) && !fixed_q && over_cap;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

// ===== hdl/ftacc_ctrl.sv =====
// Controller state machine sequencing one request through the datapath.
// Depends on ftacc_pkg.
module ftacc_ctrl
	import ftacc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.div_sel = DSEL_ACC;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_upd = 1'b1;
				state_d     = ST_DIV_A;
			end
			ST_DIV_A: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_ACC;
				state_d       = ST_WAIT_A;
			end
			ST_WAIT_A: begin
				if (status.div_done) begin
					state_d = ST_KEEP;
				end
			end
			ST_KEEP: begin
				// Quotient is now registered; decide whether the cap applies.
				if (status.need_cap) begin
					cmd.keep_calc = 1'b1;
					state_d       = ST_DIFF;
				end else begin
					state_d = ST_DIV_F;
				end
			end
			ST_DIFF: begin
				cmd.diff_calc = 1'b1;
				state_d       = ST_DIV_L;
			end
			ST_DIV_L: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_LOST;
				state_d       = ST_WAIT_L;
			end
			ST_WAIT_L: begin
				if (status.div_done) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.cap_apply = 1'b1;
				state_d       = ST_DIV_F;
			end
			ST_DIV_F: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_ALPHA;
				state_d       = ST_WAIT_F;
			end
			ST_WAIT_F: begin
				if (status.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/fixed_step_tick_accumulator_core.sv =====
// Top level of the fixed-step tick accumulator: controller plus datapath.
// Depends on ftacc_pkg, ftacc_ctrl and ftacc_dp.
//
//   Channel   Signals                          Moves
//   input     in_valid / in_ready / in_data    one request
//   output    out_valid / out_ready / out_data one result per request
//   config    cfg_we / cfg_index / cfg_data    register write, no wait
//
// A result is registered when its request is done and the output register is
// free; the next request can be taken in the cycle after. The shared
// one-bit-per-cycle divider sets the pace: two passes per request, three on a
// frame that hits the tick cap.
// Reset clears all state and loads the register defaults.
// A result waits in the output register; the next request is taken meanwhile.
module fixed_step_tick_accumulator_core
	import ftacc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  ftacc_in_t   in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output ftacc_out_t  out_data
);

	cmd_t    cmd;
	status_t status;

	ftacc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ftacc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== sim/ftacc_checker.sv =====
// Checker for the fixed-step tick accumulator: watches all channels and predicts each result.
// Keeps its own copy of the registers and state. Depends on ftacc_pkg.
module ftacc_checker
	import ftacc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [19:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  ftacc_in_t  in_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  ftacc_out_t out_data,
	output int         fail_count,
	output int         pending
);

	logic [19:0] m_num, m_den;
	logic [7:0]  m_max, m_fixed_ticks;
	logic        m_fixed_mode;
	logic [63:0] m_acc, m_tick, m_lost_total;
	logic [31:0] m_capped;
	ftacc_out_t  tick_results[$];

	assign pending = tick_results.size();

	// Prints one mismatch line and counts it.
	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	// Bitwise Q0.16 fraction of residue over step.
	function automatic logic [15:0] frac_q16(input logic [63:0] residue, input logic [63:0] step);
		logic [64:0] r;
		logic [15:0] q;
		r = {1'b0, residue};
		q = '0;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= {1'b0, step}) begin
				r = r - {1'b0, step};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// Applies one request to the model state and queues the expected result.
	task automatic predict_tick(input ftacc_in_t rq);
		logic [63:0] step, num, avail, cap, keep, lost;
		logic [7:0]  ticks;
		ftacc_out_t  res;
		step = ((m_den == 0) ? 64'd1 : 64'(m_den)) * 64'(NS_PER_SECOND);
		num = (m_num == 0) ? 64'd1 : 64'(m_num);
		ticks = '0;
		case (rq.req_type)
			REQ_FRAME: begin
				if (m_fixed_mode) begin
					ticks = m_fixed_ticks;
				end else begin
					cap = 64'(m_max);
					if (rq.frame_ns > 0)
						m_acc = m_acc + 64'(unsigned'(rq.frame_ns)) * num;
					avail = m_acc / step;
					ticks = (avail < cap) ? avail[7:0] : cap[7:0];
					if (avail > cap) begin
						keep = cap * step + m_acc % step;
						lost = (m_acc - keep) / num;
						m_lost_total = (m_lost_total > ~64'd0 - lost) ? ~64'd0
							: m_lost_total + lost;
						if (m_capped != ~32'd0)
							m_capped++;
						m_acc = keep;
					end
				end
			end
			REQ_ADVANCE: begin
				m_tick++;
				if (!m_fixed_mode)
					m_acc = (m_acc >= step) ? m_acc - step : 64'd0;
			end
			REQ_RESUME: begin
				m_tick = rq.tick_value;
				m_acc = '0;
			end
			default: ;
		endcase
		res.ticks_to_run = ticks;
		res.discarded_total_ns = m_fixed_mode ? 64'd0 : m_lost_total;
		res.alpha_fraction = m_fixed_mode ? 16'd0 : frac_q16(m_acc % step, step);
		res.capped_frame_count = m_capped;
		res.current_tick = m_tick;
		tick_results.push_back(res);
	endtask

	// Tracks register writes, accepted requests and accepted results.
	always @(posedge clk or negedge arst_n) begin
		ftacc_out_t want;
		if (!arst_n) begin
			m_num = 20'd60; m_den = 20'd1; m_max = 8'd8; m_fixed_ticks = 8'd1;
			m_fixed_mode = 1'b0; m_acc = '0; m_tick = '0; m_lost_total = '0;
			m_capped = '0; fail_count = 0;
			tick_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (tick_results.size() == 0) begin
					report("unexpected result", out_data.current_tick, 64'd0);
				end else begin
					want = tick_results.pop_front();
					if (out_data.ticks_to_run !== want.ticks_to_run)
						report("ticks_to_run", out_data.ticks_to_run, want.ticks_to_run);
					if (out_data.discarded_total_ns !== want.discarded_total_ns)
						report("discarded_total_ns", out_data.discarded_total_ns,
							want.discarded_total_ns);
					if (out_data.alpha_fraction !== want.alpha_fraction)
						report("alpha_fraction", out_data.alpha_fraction, want.alpha_fraction);
					if (out_data.capped_frame_count !== want.capped_frame_count)
						report("capped_frame_count", out_data.capped_frame_count,
							want.capped_frame_count);
					if (out_data.current_tick !== want.current_tick)
						report("current_tick", out_data.current_tick, want.current_tick);
				end
			end
			if (in_valid && in_ready)
				predict_tick(in_data);
			if (cfg_we) begin
				case (cfg_index)
					REG_RATE_NUM:    m_num = cfg_data;
					REG_RATE_DEN:    m_den = cfg_data;
					REG_MAX_TICKS:   m_max = cfg_data[7:0];
					REG_FIXED_TICKS: m_fixed_ticks = cfg_data[7:0];
					REG_FIXED_MODE:  m_fixed_mode = cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== sim/tb_fixed_step_tick_accumulator_core.sv =====
// Testbench top for the fixed-step tick accumulator: clock, reset, stimulus and verdict.
// Depends on ftacc_pkg, ftacc_checker and fixed_step_tick_accumulator_core.
module tb_fixed_step_tick_accumulator_core;
	import ftacc_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	ftacc_in_t   in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	ftacc_out_t  out_data;
	int          fail_count, pending;
	int          cycles = 0;
	int          out_gap = 0;

	always #6 clk = ~clk;

	fixed_step_tick_accumulator_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	ftacc_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// Watchdog on total cycles.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: one ready cycle, then a stall of random length.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			out_gap = gap_len();
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drops the request valid, then waits until every result has arrived, plus slack.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// Sends one request, holding it until accepted; valid stays high into a
	// following request when there is no gap.
	task automatic send_request(input logic [1:0] kind, input logic [31:0] ns,
			input logic [63:0] tick);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.req_type <= kind;
		in_data.frame_ns <= ns;
		in_data.tick_value <= tick;
		// Ready only changes at a rising edge, so it is stable here.
		while (!in_ready) @(negedge clk);
		@(negedge clk);
	endtask

	// Random request: mostly frames with believable times, some noise.
	task automatic random_request();
		int r;
		logic [31:0] ns;
		logic [63:0] tv;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0) ns = $urandom();
		else ns = $urandom_range(0, 100000000);
		tv = {$urandom(), $urandom()};
		if (r < 60) send_request(REQ_FRAME, ns, tv);
		else if (r < 82) send_request(REQ_ADVANCE, ns, tv);
		else if (r < 95) send_request(REQ_RESUME, ns, tv);
		else send_request(REQ_UNUSED, ns, tv);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		// Directed: reset defaults and edge values of each field.
		send_request(REQ_FRAME, 32'd16666667, 64'd0);
		send_request(REQ_FRAME, 32'h7FFFFFFF, 64'd0);
		send_request(REQ_FRAME, 32'h80000000, 64'd0);
		send_request(REQ_FRAME, 32'hFFFFFFFF, 64'd0);
		send_request(REQ_FRAME, 32'd0, 64'd0);
		send_request(REQ_ADVANCE, 32'd0, 64'd0);
		send_request(REQ_UNUSED, 32'd5, 64'd9);
		send_request(REQ_RESUME, 32'd0, ~64'd0);
		send_request(REQ_ADVANCE, 32'd0, 64'd0);
		send_request(REQ_RESUME, 32'd0, 64'h5555_AAAA_5555_AAAA);
		drain();
		// Zero rate terms and a zero cap.
		write_reg(REG_RATE_NUM, 20'd0);
		write_reg(REG_RATE_DEN, 20'd0);
		write_reg(REG_MAX_TICKS, 20'd0);
		send_request(REQ_FRAME, 32'h7FFFFFFF, 64'd0);
		send_request(REQ_FRAME, 32'd500000000, 64'd0);
		drain();
		// Largest rates and cap; fixed ticks above cap.
		write_reg(REG_RATE_NUM, 20'hFFFFF);
		write_reg(REG_RATE_DEN, 20'hFFFFF);
		write_reg(REG_MAX_TICKS, 20'd255);
		write_reg(REG_FIXED_TICKS, 20'd255);
		send_request(REQ_FRAME, 32'h7FFFFFFF, 64'd0);
		send_request(REQ_ADVANCE, 32'd0, 64'd0);
		drain();
		write_reg(REG_MAX_TICKS, 20'd3);
		write_reg(REG_FIXED_MODE, 20'd1);
		send_request(REQ_FRAME, 32'd1000, 64'd0);
		send_request(REQ_ADVANCE, 32'd0, 64'd0);
		send_request(REQ_RESUME, 32'd0, 64'd77);
		drain();
		// Random phases with varied register settings.
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(REG_RATE_NUM, (ph % 4 == 0) ? 20'hFFFFF : 20'($urandom_range(0, 2000)));
			write_reg(REG_RATE_DEN, (ph % 4 == 1) ? 20'hFFFFF : 20'($urandom_range(0, 8)));
			write_reg(REG_MAX_TICKS, (ph % 3 == 0) ? 20'd255 : 20'($urandom_range(0, 12)));
			write_reg(REG_FIXED_TICKS, 20'($urandom_range(0, 255)));
			write_reg(REG_FIXED_MODE, (ph % 5 == 4) ? 20'd1 : 20'hFFFFE);
			for (int k = 0; k < 50; k++) random_request();
			drain();
		end
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ftacc_pkg.sv
hdl/ftacc_div.sv
hdl/ftacc_dp.sv
hdl/ftacc_ctrl.sv
hdl/fixed_step_tick_accumulator_core.sv
sim/ftacc_checker.sv
sim/tb_fixed_step_tick_accumulator_core.sv
